[sv/rxrf_pkg.sv]
// Shared constants, codes and helpers for the receive byte ring buffer.
// Used by rx_byte_ring_fifo; has no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package rxrf_pkg;

  // Storage geometry.
  localparam int BUFFER_DEPTH = 256;
  localparam int PTR_W        = $clog2(BUFFER_DEPTH);
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

  // Field widths of the two channels.
  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;
  localparam int LIM_W  = 7;
  localparam int STAT_W = 2;
  localparam int FILL_W = 9;
  localparam int OVF_W  = 32;

  // Common width for comparing the fill count against the burst limit.
  localparam int CMP_W = (CNT_W > LIM_W) ? CNT_W : LIM_W;

  // Largest number of bytes one burst pop returns.
  localparam logic [LIM_W-1:0] BURST_MAX = LIM_W'(64);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // Advance a ring pointer, wrapping at the buffer depth.
  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    n = p + 1'b1;
    if (p == PTR_W'(BUFFER_DEPTH - 1)) begin
      n = '0;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

[sv/rxrf_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rxrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data register holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/rx_byte_ring_fifo.sv]
// Push, flush and empty-pop results are registered, in the cycle after the transfer.
// A burst pop reads its first byte from the byte store and registers it, then gives one
// byte per cycle while the output is not stalled. Push and flush take one item per cycle
// if not stalled; the single read port makes a burst pop hold the input to its last byte.
// Reset (synchronous, active low) clears pointers, fill count and overflow count;
// the byte store is not cleared, since entries are only read after being written.
`timescale 1ns / 1ps
`default_nettype none

module rx_byte_ring_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input channel.
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [rxrf_pkg::CMD_W-1:0]    in_command,
  input  wire logic [rxrf_pkg::BYTE_W-1:0]   in_push_byte,
  input  wire logic [rxrf_pkg::LIM_W-1:0]    in_read_limit,
  // Result channel.
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [rxrf_pkg::BYTE_W-1:0]   out_byte,
  output logic                               out_has_byte,
  output logic                               out_last_of_run,
  output logic      [rxrf_pkg::STAT_W-1:0]   out_status,
  output logic      [rxrf_pkg::FILL_W-1:0]   out_fill_level,
  output logic      [rxrf_pkg::OVF_W-1:0]    out_overflow_total
);

  import rxrf_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_POP  = 1'b1;

  // Control state.
  logic             state_r,  state_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic [OVF_W-1:0] drop_r,   drop_nxt;
  logic [LIM_W-1:0] remain_r, remain_nxt;

  // Output register.
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_has_r;
  logic              out_last_r;
  logic [STAT_W-1:0] out_status_r;
  logic [FILL_W-1:0] out_fill_r;
  logic [OVF_W-1:0]  out_ovf_r;

  // Byte store port signals.
  logic              ram_we;
  logic              ram_re;
  logic [PTR_W-1:0]  ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  // Result being loaded this cycle.
  logic              load_out;
  logic [BYTE_W-1:0] ld_byte;
  logic              ld_has;
  logic              ld_last;
  logic [STAT_W-1:0] ld_status;

  logic                    out_free;
  logic                    in_fire;
  logic [LIM_W-1:0]        lim_sat;
  logic [CMP_W-1:0]        count_cmp;
  logic [CMP_W-1:0]        take_cmp;
  logic [LIM_W-1:0]        take;
  logic [CNT_W+FILL_W-1:0] fill_wide;

  // The output slot can take a new result when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_fire  = in_valid && !in_stall;

  // Burst length: the held count, capped by the saturated request limit.
  assign lim_sat   = (in_read_limit > BURST_MAX) ? BURST_MAX : in_read_limit;
  assign count_cmp = CMP_W'(count_r);
  assign take_cmp  = (count_cmp < CMP_W'(lim_sat)) ? count_cmp : CMP_W'(lim_sat);
  assign take      = take_cmp[LIM_W-1:0];

  // Byte store.
  rxrf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata (in_push_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Command handling and burst sequencing.
  always_comb begin
    state_nxt  = state_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    drop_nxt   = drop_r;
    remain_nxt = remain_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = rd_ptr_r;
    load_out   = 1'b0;
    ld_byte    = '0;
    ld_has     = 1'b0;
    ld_last    = 1'b1;
    ld_status  = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_command)
            CMD_PUSH: begin
              load_out = 1'b1;
              if (count_r < CNT_W'(BUFFER_DEPTH)) begin
                ram_we     = 1'b1;
                wr_ptr_nxt = next_ptr(wr_ptr_r);
                count_nxt  = count_r + 1'b1;
              end else begin
                drop_nxt  = drop_r + 1'b1;
                ld_status = ST_FULL;
              end
            end
            CMD_POP: begin
              if (take == '0) begin
                load_out  = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                // Fetch the first byte; it is delivered from the POP state.
                ram_re     = 1'b1;
                rd_ptr_nxt = next_ptr(rd_ptr_r);
                remain_nxt = take;
                state_nxt  = S_POP;
              end
            end
            CMD_FLUSH: begin
              load_out   = 1'b1;
              wr_ptr_nxt = '0;
              rd_ptr_nxt = '0;
              count_nxt  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        // Deliver the fetched byte; if more remain, prefetch the next in the same cycle.
        if (out_free) begin
          load_out   = 1'b1;
          ld_byte    = ram_rdata;
          ld_has     = 1'b1;
          ld_last    = (remain_r == LIM_W'(1));
          count_nxt  = count_r - 1'b1;
          remain_nxt = remain_r - 1'b1;
          if (remain_r != LIM_W'(1)) begin
            ram_re     = 1'b1;
            rd_ptr_nxt = next_ptr(rd_ptr_r);
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      drop_r   <= '0;
      remain_r <= '0;
    end else begin
      state_r  <= state_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      drop_r   <= drop_nxt;
      remain_r <= remain_nxt;
    end
  end

  // Fill level reports the count as updated this cycle, which fits the fill width in full.
  assign fill_wide = {{FILL_W{1'b0}}, count_nxt};

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_byte_r   <= ld_byte;
      out_has_r    <= ld_has;
      out_last_r   <= ld_last;
      out_status_r <= ld_status;
      out_fill_r   <= fill_wide[FILL_W-1:0];
      out_ovf_r    <= drop_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte           = out_byte_r;
  assign out_has_byte       = out_has_r;
  assign out_last_of_run    = out_last_r;
  assign out_status         = out_status_r;
  assign out_fill_level     = out_fill_r;
  assign out_overflow_total = out_ovf_r;

  // A burst in progress always has bytes left to deliver.
  a_pop_remain : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> (remain_r != '0))
    else $error("burst state with no bytes remaining");

  // The held count never exceeds the buffer depth.
  a_count_max : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(BUFFER_DEPTH))
    else $error("held count above buffer depth");

  // An idle, empty buffer has its pointers together.
  a_empty_ptrs : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty buffer with pointers apart");

  // The final byte of a burst is marked as the end of the run.
  a_last_mark : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP && remain_r == LIM_W'(1) && out_free)
      |=> (out_valid_r && out_last_r && out_has_r && state_r == S_IDLE))
    else $error("final burst byte not marked last");

endmodule

`default_nettype wire
